// File: hdl/fvp_pkg.sv
package fvp_pkg;

   localparam int DATA_W     = 32;
   localparam int OPND_W     = 24;              // operand after the >>8
   localparam int MAT_DEPTH  = 16;
   localparam int MAT_IDX_W  = 4;
   localparam int ORIGIN_W   = 10;
   localparam int SIZE_W     = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int DIV_STAGES = DATA_W;

   localparam logic [DATA_W-1:0]   HALF_OFFSET     = 32'h0000_0100;
   localparam logic [DATA_W-1:0]   ONE_FIXED       = 32'h0001_0000;
   localparam logic [ORIGIN_W-1:0] ORIGIN_X_RESET  = 10'd0;
   localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RESET  = 10'd0;
   localparam logic [SIZE_W-1:0]   WIDTH_RESET     = 11'd240;
   localparam logic [SIZE_W-1:0]   HEIGHT_RESET    = 11'd160;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_VERTEX = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_WIDTH    = 2'd2,
      CSR_HEIGHT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic zero;
   } div_tag_type;

   typedef struct packed {
      logic [ORIGIN_W-1:0] origin_x;
      logic [ORIGIN_W-1:0] origin_y;
      logic [SIZE_W-1:0]   width;
      logic [SIZE_W-1:0]   height;
   } view_cfg_type;

endpackage

// File: hdl/fvp_xform.sv
module fvp_xform (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       adv,
   input  logic                                       in_valid,
   input  logic [fvp_pkg::MAT_DEPTH-1:0][fvp_pkg::DATA_W-1:0] mat,
   input  logic [fvp_pkg::DATA_W-1:0]                 vx,
   input  logic [fvp_pkg::DATA_W-1:0]                 vy,
   input  logic [fvp_pkg::DATA_W-1:0]                 vz,
   output logic                                       out_valid,
   output logic [fvp_pkg::DATA_W-1:0]                 tx,
   output logic [fvp_pkg::DATA_W-1:0]                 ty,
   output logic [fvp_pkg::DATA_W-1:0]                 tz
);

   localparam int W  = fvp_pkg::DATA_W;
   localparam int OW = fvp_pkg::OPND_W;

   logic [2:0][2:0][W-1:0] prod_in, prod_ff;
   logic [2:0][W-1:0]      trans_ff;
   logic                   pv_ff;
   logic [2:0][W-1:0]      sum_in, sum_ff;
   logic                   sv_ff;
   logic [2:0][W-1:0]      vin;

   assign vin = {vz, vy, vx};

   // product [row][col] = (m[4*col+row] >>> 8) * (v[col] >>> 8), low word
   always_comb begin
      logic signed [OW-1:0]   ms;
      logic signed [OW-1:0]   vs;
      logic signed [2*OW-1:0] p;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            ms = $signed(mat[4*c + r][W-1:W-OW]);
            vs = $signed(vin[c][W-1:W-OW]);
            p  = ms * vs;
            prod_in[r][c] = p[W-1:0];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = prod_ff[r][0] + prod_ff[r][1] + prod_ff[r][2] + trans_ff[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         sv_ff <= 1'b0;
      end else if (adv) begin
         pv_ff <= in_valid;
         sv_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff  <= prod_in;
         trans_ff <= {mat[14], mat[13], mat[12]};
         sum_ff   <= sum_in;
      end
   end

   assign out_valid = sv_ff;
   assign tx        = sum_ff[0];
   assign ty        = sum_ff[1];
   assign tz        = sum_ff[2];

endmodule

// File: hdl/fvp_div.sv
module fvp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [fvp_pkg::DATA_W-1:0] tx,
   input  logic [fvp_pkg::DATA_W-1:0] ty,
   input  logic [fvp_pkg::DATA_W-1:0] tz,
   output logic                       out_valid,
   output logic [fvp_pkg::DATA_W-1:0] px,
   output logic [fvp_pkg::DATA_W-1:0] py,
   output logic                       zero
);

   localparam int W = fvp_pkg::DATA_W;
   localparam int N = fvp_pkg::DIV_STAGES;

   logic [W-1:0]             d_in, nx_in, ny_in;
   fvp_pkg::div_tag_type     tag_in;

   logic [N:0]               v_ff;
   fvp_pkg::div_tag_type     tag_ff [N+1];
   logic [W-1:0]             den_ff [N+1];
   logic [W-1:0]             rx_ff  [N+1];
   logic [W-1:0]             ry_ff  [N+1];
   logic [W-1:0]             wx_ff  [N+1];
   logic [W-1:0]             wy_ff  [N+1];

   logic                     ov_ff;
   logic [W-1:0]             px_ff, py_ff;
   logic                     zero_ff;

   // numerators x<<1, y<<2 and divisor z>>>8, split into sign and magnitude
   always_comb begin
      logic [W-1:0] nx;
      logic [W-1:0] ny;
      nx   = {tx[W-2:0], 1'b0};
      ny   = {ty[W-3:0], 2'b00};
      d_in = W'($signed(tz) >>> 8);
      tag_in.zero  = (d_in == '0);
      tag_in.neg_x = nx[W-1] ^ d_in[W-1];
      tag_in.neg_y = ny[W-1] ^ d_in[W-1];
      nx_in = nx[W-1] ? (~nx + 1'b1) : nx;
      ny_in = ny[W-1] ? (~ny + 1'b1) : ny;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff[0] <= tag_in;
         den_ff[0] <= d_in[W-1] ? (~d_in + 1'b1) : d_in;
         rx_ff[0]  <= '0;
         ry_ff[0]  <= '0;
         wx_ff[0]  <= nx_in;
         wy_ff[0]  <= ny_in;
      end
   end

   // one restoring step per stage; w shifts the dividend out and the quotient in
   for (genvar s = 0; s < N; s++) begin : g_step
      logic [W:0]   tx2, ty2;
      logic         qx, qy;
      logic [W-1:0] rx_n, ry_n;

      always_comb begin
         tx2  = {rx_ff[s], wx_ff[s][W-1]};
         ty2  = {ry_ff[s], wy_ff[s][W-1]};
         qx   = (tx2 >= {1'b0, den_ff[s]});
         qy   = (ty2 >= {1'b0, den_ff[s]});
         rx_n = qx ? W'(tx2 - {1'b0, den_ff[s]}) : tx2[W-1:0];
         ry_n = qy ? W'(ty2 - {1'b0, den_ff[s]}) : ty2[W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else if (adv) begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            tag_ff[s+1] <= tag_ff[s];
            den_ff[s+1] <= den_ff[s];
            rx_ff[s+1]  <= rx_n;
            ry_ff[s+1]  <= ry_n;
            wx_ff[s+1]  <= {wx_ff[s][W-2:0], qx};
            wy_ff[s+1]  <= {wy_ff[s][W-2:0], qy};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= v_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff   <= tag_ff[N].neg_x ? (~wx_ff[N] + 1'b1) : wx_ff[N];
         py_ff   <= tag_ff[N].neg_y ? (~wy_ff[N] + 1'b1) : wy_ff[N];
         zero_ff <= tag_ff[N].zero;
      end
   end

   assign out_valid = ov_ff;
   assign px        = px_ff;
   assign py        = py_ff;
   assign zero      = zero_ff;

endmodule

// File: hdl/fvp_view.sv
module fvp_view (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [fvp_pkg::DATA_W-1:0] px,
   input  logic [fvp_pkg::DATA_W-1:0] py,
   input  logic                       zero,
   input  fvp_pkg::view_cfg_type      cfg,
   output logic                       out_valid,
   output logic [fvp_pkg::DATA_W-1:0] sx,
   output logic [fvp_pkg::DATA_W-1:0] sy,
   output logic                       out_zero
);

   localparam int W  = fvp_pkg::DATA_W;
   localparam int SW = fvp_pkg::SIZE_W;

   logic [W-1:0] mx_in, my_in, mx_ff, my_ff;
   logic         v1_ff, z1_ff, v2_ff, z2_ff;
   logic [W-1:0] sx_ff, sy_ff;

   always_comb begin
      logic signed [W-1:0]    ax;
      logic signed [W-1:0]    ay;
      logic signed [W+SW:0]   pxl;
      logic signed [W+SW:0]   pyl;
      ax    = $signed(px + fvp_pkg::HALF_OFFSET) >>> 1;
      ay    = $signed(fvp_pkg::HALF_OFFSET - py) >>> 1;
      pxl   = ax * $signed({1'b0, cfg.width});
      pyl   = ay * $signed({1'b0, cfg.height});
      mx_in = pxl[W-1:0];
      my_in = pyl[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
         z1_ff <= zero;
         z2_ff <= z1_ff;
         sx_ff <= z1_ff ? '0 :
                  W'($signed(mx_ff) >>> 8) + W'(cfg.origin_x);
         sy_ff <= z1_ff ? '0 :
                  W'($signed(my_ff) >>> 8) + W'(cfg.origin_y);
      end
   end

   assign out_valid = v2_ff;
   assign sx        = sx_ff;
   assign sy        = sy_ff;
   assign out_zero  = z2_ff;

endmodule

// File: hdl/fixed_point_vertex_project_unit.sv
// channel | direction | handshake            | words
// req     | in        | req_valid/req_ready  | matrix load or vertex
// rsp     | out       | rsp_valid/rsp_ready  | screen x, y, depth_zero per vertex
// csr     | in        | csr_valid/csr_ready  | viewport register write
//
// One word per cycle sustained while the skid register is empty; a vertex passes these stages from accept to rsp_valid:
// 2 transform, 1 divide setup, 32 divider steps (one quotient bit each), 1 sign fix,
// 2 viewport. Matrix loads write at entry and give no word.
// Reset (synchronous) restores the identity matrix and viewport defaults.
// A stalled rsp freezes the pipe only once the output skid register is full.
module fixed_point_vertex_project_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [0:0]                    req_type,
   input  logic [fvp_pkg::MAT_IDX_W-1:0] req_matrix_index,
   input  logic [fvp_pkg::DATA_W-1:0]    req_matrix_value,
   input  logic [fvp_pkg::DATA_W-1:0]    req_vertex_x,
   input  logic [fvp_pkg::DATA_W-1:0]    req_vertex_y,
   input  logic [fvp_pkg::DATA_W-1:0]    req_vertex_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fvp_pkg::DATA_W-1:0]    rsp_screen_x,
   output logic [fvp_pkg::DATA_W-1:0]    rsp_screen_y,
   output logic                          rsp_depth_zero,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fvp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fvp_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int W = fvp_pkg::DATA_W;

   logic [fvp_pkg::MAT_DEPTH-1:0][W-1:0] mat_ff;
   fvp_pkg::view_cfg_type                cfg_ff;

   logic         adv, req_fire, vtx_in;
   logic         xv, dv, vv, vz;
   logic [W-1:0] tx, ty, tz, px, py, sx, sy;
   logic         dz;

   logic         skid_valid_ff;
   logic [W-1:0] skid_x_ff, skid_y_ff;
   logic         skid_z_ff;

   assign adv       = !skid_valid_ff;
   assign req_ready = adv;
   assign req_fire  = req_valid && req_ready;
   assign vtx_in    = req_fire && (req_type == fvp_pkg::REQ_VERTEX);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fvp_pkg::MAT_DEPTH; i++) begin
            mat_ff[i] <= (i % 5 == 0) ? fvp_pkg::ONE_FIXED : '0;
         end
      end else if (req_fire && (req_type == fvp_pkg::REQ_LOAD)) begin
         mat_ff[req_matrix_index] <= req_matrix_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= fvp_pkg::ORIGIN_X_RESET;
         cfg_ff.origin_y <= fvp_pkg::ORIGIN_Y_RESET;
         cfg_ff.width    <= fvp_pkg::WIDTH_RESET;
         cfg_ff.height   <= fvp_pkg::HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (fvp_pkg::csr_index_type'(csr_index))
            fvp_pkg::CSR_ORIGIN_X: cfg_ff.origin_x <= csr_data[fvp_pkg::ORIGIN_W-1:0];
            fvp_pkg::CSR_ORIGIN_Y: cfg_ff.origin_y <= csr_data[fvp_pkg::ORIGIN_W-1:0];
            fvp_pkg::CSR_WIDTH:    cfg_ff.width    <= csr_data[fvp_pkg::SIZE_W-1:0];
            fvp_pkg::CSR_HEIGHT:   cfg_ff.height   <= csr_data[fvp_pkg::SIZE_W-1:0];
            default:               cfg_ff          <= cfg_ff;
         endcase
      end
   end

   fvp_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vtx_in),
      .mat       (mat_ff),
      .vx        (req_vertex_x),
      .vy        (req_vertex_y),
      .vz        (req_vertex_z),
      .out_valid (xv),
      .tx        (tx),
      .ty        (ty),
      .tz        (tz)
   );

   fvp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (xv),
      .tx        (tx),
      .ty        (ty),
      .tz        (tz),
      .out_valid (dv),
      .px        (px),
      .py        (py),
      .zero      (dz)
   );

   fvp_view u_view (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv),
      .px        (px),
      .py        (py),
      .zero      (dz),
      .cfg       (cfg_ff),
      .out_valid (vv),
      .sx        (sx),
      .sy        (sy),
      .out_zero  (vz)
   );

   // skid holds the older word; the pipe freezes while it is full
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) skid_valid_ff <= 1'b0;
      end else if (vv && !rsp_ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_x_ff <= sx;
         skid_y_ff <= sy;
         skid_z_ff <= vz;
      end
   end

   assign rsp_valid      = skid_valid_ff || vv;
   assign rsp_screen_x   = skid_valid_ff ? skid_x_ff : sx;
   assign rsp_screen_y   = skid_valid_ff ? skid_y_ff : sy;
   assign rsp_depth_zero = skid_valid_ff ? skid_z_ff : vz;

endmodule

// File: hdl/fvp_check.sv
module fvp_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [fvp_pkg::DATA_W-1:0] rsp_screen_x,
   input logic [fvp_pkg::DATA_W-1:0] rsp_screen_y,
   input logic                       rsp_depth_zero
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x)
         && $stable(rsp_screen_y) && $stable(rsp_depth_zero))
      else $error("rsp word changed while stalled");

   // a zero divisor gives a zero coordinate pair
   a_zero_coord: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_depth_zero |-> rsp_screen_x == '0 && rsp_screen_y == '0)
      else $error("depth_zero word with nonzero coordinates");

   // pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid right after reset");

endmodule

bind fixed_point_vertex_project_unit fvp_check u_fvp_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_screen_x   (rsp_screen_x),
   .rsp_screen_y   (rsp_screen_y),
   .rsp_depth_zero (rsp_depth_zero)
);

// File: test/fixed_point_vertex_project_checker.sv
`timescale 1ns / 1ps

module fixed_point_vertex_project_checker
   import fvp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [0:0]            req_type,
   input  logic [MAT_IDX_W-1:0]  req_matrix_index,
   input  logic [DATA_W-1:0]     req_matrix_value,
   input  logic [DATA_W-1:0]     req_vertex_x,
   input  logic [DATA_W-1:0]     req_vertex_y,
   input  logic [DATA_W-1:0]     req_vertex_z,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [DATA_W-1:0]     rsp_screen_x,
   input  logic [DATA_W-1:0]     rsp_screen_y,
   input  logic                  rsp_depth_zero,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   typedef struct {
      logic [DATA_W-1:0] screen_x;
      logic [DATA_W-1:0] screen_y;
      logic              depth_zero;
   } screen_point_type;

   logic [DATA_W-1:0] matrix_words [MAT_DEPTH];
   view_cfg_type      view;
   screen_point_type  screen_queue [$];

   // (a>>>8)*(b>>>8), low 32 bits kept
   function automatic logic [DATA_W-1:0] fix_mul(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      longint pa;
      longint pb;
      longint prod;
      pa = longint'($signed(a)) >>> 8;
      pb = longint'($signed(b)) >>> 8;
      prod = pa * pb;
      return prod[DATA_W-1:0];
   endfunction

   function automatic logic [DATA_W-1:0] xform_row(int r, logic [DATA_W-1:0] x,
                                                   logic [DATA_W-1:0] y, logic [DATA_W-1:0] z);
      return fix_mul(matrix_words[r], x) + fix_mul(matrix_words[4 + r], y)
           + fix_mul(matrix_words[8 + r], z) + matrix_words[12 + r];
   endfunction

   function automatic logic [DATA_W-1:0] trunc_div(logic [DATA_W-1:0] num, logic [DATA_W-1:0] den);
      longint q;
      q = longint'($signed(num)) / longint'($signed(den));
      return q[DATA_W-1:0];
   endfunction

   function automatic screen_point_type project_vertex(logic [DATA_W-1:0] x,
                                                       logic [DATA_W-1:0] y,
                                                       logic [DATA_W-1:0] z);
      screen_point_type pt;
      logic [DATA_W-1:0] tx, ty, tz, depth, px, py, acc;
      tx = xform_row(0, x, y, z);
      ty = xform_row(1, x, y, z);
      tz = xform_row(2, x, y, z);
      depth = $signed(tz) >>> 8;
      pt.screen_x = '0;
      pt.screen_y = '0;
      pt.depth_zero = 1'b1;
      if (depth != '0) begin
         px = trunc_div(tx << 1, depth);
         py = trunc_div(ty << 2, depth);
         acc = px + HALF_OFFSET;
         acc = $signed(acc) >>> 1;
         acc = acc * {21'b0, view.width};
         acc = $signed(acc) >>> 8;
         pt.screen_x = acc + {22'b0, view.origin_x};
         acc = HALF_OFFSET - py;
         acc = $signed(acc) >>> 1;
         acc = acc * {21'b0, view.height};
         acc = $signed(acc) >>> 8;
         pt.screen_y = acc + {22'b0, view.origin_y};
         pt.depth_zero = 1'b0;
      end
      return pt;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      screen_point_type want;
      if (reset) begin
         for (int i = 0; i < MAT_DEPTH; i++)
            matrix_words[i] = (i % 5 == 0) ? ONE_FIXED : '0;
         view.origin_x = ORIGIN_X_RESET;
         view.origin_y = ORIGIN_Y_RESET;
         view.width    = WIDTH_RESET;
         view.height   = HEIGHT_RESET;
         screen_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_ORIGIN_X: view.origin_x = csr_data[ORIGIN_W-1:0];
               CSR_ORIGIN_Y: view.origin_y = csr_data[ORIGIN_W-1:0];
               CSR_WIDTH:    view.width    = csr_data;
               CSR_HEIGHT:   view.height   = csr_data;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (screen_queue.size() == 0) begin
               $display("%0t: unexpected word on rsp", $realtime);
               fail_count++;
            end else begin
               want = screen_queue.pop_front();
               if (rsp_screen_x !== want.screen_x)
                  report_mismatch("screen_x", rsp_screen_x, want.screen_x);
               if (rsp_screen_y !== want.screen_y)
                  report_mismatch("screen_y", rsp_screen_y, want.screen_y);
               if (rsp_depth_zero !== want.depth_zero)
                  report_mismatch("depth_zero", {31'b0, rsp_depth_zero}, {31'b0, want.depth_zero});
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind_type'(req_type) == REQ_LOAD)
               matrix_words[req_matrix_index] = req_matrix_value;
            else
               screen_queue.push_back(project_vertex(req_vertex_x, req_vertex_y, req_vertex_z));
         end
      end
      pending = screen_queue.size();
   end

endmodule

// File: test/fixed_point_vertex_project_unit_tb.sv
`timescale 1ns / 1ps

module fixed_point_vertex_project_unit_tb;
   import fvp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PIPE_DRAIN  = 45;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [0:0]            req_type;
   logic [MAT_IDX_W-1:0]  req_matrix_index;
   logic [DATA_W-1:0]     req_matrix_value;
   logic [DATA_W-1:0]     req_vertex_x;
   logic [DATA_W-1:0]     req_vertex_y;
   logic [DATA_W-1:0]     req_vertex_z;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [DATA_W-1:0]     rsp_screen_x;
   logic [DATA_W-1:0]     rsp_screen_y;
   logic                  rsp_depth_zero;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int  fail_count;
   int  pending;
   int  cycle_count;
   int  words_sent;
   int  burst_left;
   logic req_fired;
   logic csr_fired;

   fixed_point_vertex_project_unit u_dut (.*);

   fixed_point_vertex_project_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      req_fired <= req_valid && req_ready;
      csr_fired <= csr_valid && csr_ready;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: one long hold-off, otherwise a changing stall pattern
   initial begin
      int mode;
      int span;
      logic held;
      held = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(16, 96);
         repeat (span) begin
            if (!held && words_sent >= 300) begin
               held = 1'b1;
               rsp_ready <= 1'b0;
               repeat (400) @(negedge clock);
            end
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= $urandom_range(0, 1);
               default: rsp_ready <= ($urandom_range(0, 4) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(req_kind_type kind, logic [MAT_IDX_W-1:0] idx, logic [DATA_W-1:0] val,
                            logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic [DATA_W-1:0] z);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0 && req_valid) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_matrix_index <= idx;
      req_matrix_value <= val;
      req_vertex_x     <= x;
      req_vertex_y     <= y;
      req_vertex_z     <= z;
      do @(negedge clock); while (!req_fired);
      words_sent++;
   endtask

   task automatic send_vertex(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic [DATA_W-1:0] z);
      send_word(REQ_VERTEX, MAT_IDX_W'($urandom), $urandom, x, y, z);
   endtask

   task automatic send_load(logic [MAT_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      send_word(REQ_LOAD, idx, val, $urandom, $urandom, $urandom);
   endtask

   // wait for the pipe to empty, then rewrite all four viewport registers
   task automatic set_viewport(logic [CSR_DATA_W-1:0] ox, logic [CSR_DATA_W-1:0] oy,
                               logic [CSR_DATA_W-1:0] w, logic [CSR_DATA_W-1:0] h);
      logic [CSR_DATA_W-1:0] vals [4];
      vals = '{ox, oy, w, h};
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= vals[i];
         do @(negedge clock); while (!csr_fired);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] small_coord();
      return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
   endfunction

   task automatic random_phase(int count);
      int n;
      int pick;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            // whole matrix: scaled diagonal, small terms, translation pushes z forward
            for (int i = 0; i < MAT_DEPTH; i++) begin
               if (i % 5 == 0)
                  send_load(MAT_IDX_W'(i), $urandom_range(32'h0000_4000, 32'h0004_0000));
               else if (i == 14)
                  send_load(MAT_IDX_W'(i), $urandom_range(32'h0002_0000, 32'h0040_0000));
               else
                  send_load(MAT_IDX_W'(i), small_coord() >> ($urandom_range(0, 4)));
            end
            n += MAT_DEPTH;
         end else if (pick < 10) begin
            send_load(MAT_IDX_W'($urandom), $urandom);
            n++;
         end else if (pick < 75) begin
            send_vertex(small_coord(), small_coord(),
                        $urandom_range(32'h0000_8000, 32'h0010_0000));
            n++;
         end else if (pick < 80) begin
            send_vertex(small_coord(), small_coord(), $urandom_range(0, 511) - 256);
            n++;
         end else begin
            send_vertex($urandom, $urandom, $urandom);
            n++;
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = REQ_LOAD;
      req_matrix_index = '0;
      req_matrix_value = '0;
      req_vertex_x     = '0;
      req_vertex_y     = '0;
      req_vertex_z     = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_ORIGIN_X;
      csr_data         = '0;
      cycle_count      = 0;
      words_sent       = 0;
      burst_left       = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset viewport and identity matrix
      send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);   // zero depth
      send_vertex(32'h1234_5678, 32'h0000_8000, 32'h0000_00ff);   // zero depth, top of band
      send_vertex(32'h4000_0000, 32'h0000_0000, 32'hffff_ffff);   // divide overflow
      send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_vertex(32'hffff_ffff, 32'hffff_ffff, 32'h0000_0100);
      send_load(4'd0, 32'h7fff_ffff);
      send_load(4'd15, 32'h8000_0000);
      send_vertex(32'h0002_0000, 32'hfffe_0000, 32'h0003_0000);
      send_load(4'd0, 32'h0001_0000);
      send_load(4'd15, 32'h0001_0000);
      send_load(4'd14, 32'h0002_0000);
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_load(4'd14, 32'h0000_0000);
      send_vertex(32'h0003_0000, 32'h0001_8000, 32'h0002_0000);

      random_phase(200);
      set_viewport(11'd0, 11'd0, 11'd1, 11'd1);
      random_phase(200);
      set_viewport(11'd1023, 11'd1023, 11'd1024, 11'd1024);
      random_phase(200);
      // out-of-range sizes, origins with the unused top bit set
      set_viewport(11'h7ff, 11'h400, 11'd0, 11'h7ff);
      random_phase(200);
      set_viewport(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                   CSR_DATA_W'($urandom_range(1, 1024)), CSR_DATA_W'($urandom_range(1, 1024)));
      random_phase(200);

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
